// ----- hdl/sha256_hash_engine_macros.svh -----
// Assertion helpers for the hash engine checker.
`ifndef SHA256_HASH_ENGINE_MACROS_SVH
`define SHA256_HASH_ENGINE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, quiet during reset.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, quiet during reset.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sha256_pkg.sv -----
package sha256_pkg;

    typedef logic [31:0] t_words [8];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic wr_byte;
        logic load_vars;
        logic step;
    } t_ctrl;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [5:0] FILL_LAST     = 6'd63;
    localparam logic [5:0] FILL_LEN_AT   = 6'd56;
    localparam logic [2:0] LAST_INDEX    = 3'd7;

    localparam t_words INIT_H = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- hdl/sha256_round.sv -----
// Working variables a..h and the round function, one round per step.
module sha256_round
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  t_ctrl       i_ctrl,
    input  t_words      i_chain,
    input  logic [31:0] i_w,
    input  logic [31:0] i_k,
    output t_words      o_vars
);

    t_words      r_var;
    t_words      n_var;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;

    always_comb begin
        w_ch  = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        w_maj = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        w_t1  = r_var[7] + big_sigma1(r_var[4]) + w_ch + i_k + i_w;
        w_t2  = big_sigma0(r_var[0]) + w_maj;
        n_var = r_var;
        if (i_ctrl.load_vars) begin
            n_var = i_chain;
        end else if (i_ctrl.step) begin
            n_var[7] = r_var[6];
            n_var[6] = r_var[5];
            n_var[5] = r_var[4];
            n_var[4] = r_var[3] + w_t1;
            n_var[3] = r_var[2];
            n_var[2] = r_var[1];
            n_var[1] = r_var[0];
            n_var[0] = w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_var <= n_var;
    end

    assign o_vars = r_var;

endmodule

// ----- hdl/sha256_sched.sv -----
// Block buffer doubling as the 16-word rolling schedule window.
// Bytes land big-endian in the word picked by the fill count; during the
// rounds the window shifts down one word a step with the new word at the top.
module sha256_sched
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  t_ctrl       i_ctrl,
    input  logic [5:0]  i_fill,
    input  logic [7:0]  i_byte,
    input  logic        i_early,
    output logic [31:0] o_w
);

    logic [31:0] r_win [16];
    logic [31:0] w_next;

    always_comb begin
        w_next = small_sigma1(r_win[14]) + r_win[9] + small_sigma0(r_win[1]) + r_win[0];
        o_w    = i_early ? r_win[0] : w_next;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_byte) begin
            r_win[i_fill[5:2]][{~i_fill[1:0], 3'b000} +: 8] <= i_byte;
        end else if (i_ctrl.step) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= o_w;
        end
    end

endmodule

// ----- hdl/sha256_hash_engine.sv -----
// SHA-256 hash engine, byte-serial in, digest word-serial out.
// Input channel: i_valid/o_stall carry one message byte a word, with
// i_has_byte (0 only on an empty final word) and i_last_item ending the message.
// Output channel: o_valid/i_stall carry the eight digest words, index 0 first,
// o_last_word set on index 7.
// Timing: the 64th byte of a block holds o_stall high through 64 rounds in the
// single shared round unit, then a fold of the result into the chaining words,
// so no byte is taken until that compression is over. A final word adds
// padding written one byte a cycle, plus a step that writes nothing on reaching
// the length field, one or two compressions, then the digest words, one a cycle
// while i_stall is low. o_stall stays high from the final word until the eighth
// digest word has been taken.
// While i_stall is high the current digest word and its index hold.
// Reset (synchronous, active low) returns the engine to idle with the initial
// chaining values and an empty message; the block buffer is not cleared, as
// every byte is written before a compression reads it.
module sha256_hash_engine
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state      r_state;
    t_state      n_state;
    logic [5:0]  r_fill;
    logic [5:0]  n_fill;
    logic [60:0] r_total;
    logic [60:0] n_total;
    t_words      r_chain;
    t_words      n_chain;
    logic [5:0]  r_round;
    logic [2:0]  r_oidx;
    logic        r_last_pend;
    logic        r_pad;
    logic        r_len_done;

    t_ctrl       w_ctrl;
    logic [7:0]  w_byte;
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_out_done;
    logic [63:0] w_bits;
    logic [7:0]  w_len_byte;
    logic [31:0] w_w;
    t_words      w_vars;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_acc  = o_valid && !i_stall;
    assign w_out_done = w_out_acc && (r_oidx == LAST_INDEX);

    // length field, big-endian, picked by the low fill bits (56..63)
    assign w_bits     = {r_total, 3'b000};
    assign w_len_byte = 8'(w_bits >> {~r_fill[2:0], 3'b000});

    sha256_round u_round (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_chain (r_chain),
        .i_w     (w_w),
        .i_k     (ROUND_K[r_round]),
        .o_vars  (w_vars)
    );

    sha256_sched u_sched (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_fill  (r_fill),
        .i_byte  (w_byte),
        .i_early (r_round[5:4] == 2'b00),
        .o_w     (w_w)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_has_byte && (r_fill == FILL_LAST)) begin
                        n_state = ST_ROUND;
                    end else if (i_last_item) begin
                        n_state = ST_PAD_MARK;
                    end
                end
            end
            ST_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_len_done) begin
                    n_state = ST_OUT;
                end else if (r_pad) begin
                    n_state = ST_PAD_ZERO;
                end else if (r_last_pend) begin
                    n_state = ST_PAD_MARK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD_MARK: begin
                n_state = (r_fill == FILL_LAST) ? ST_ROUND : ST_PAD_ZERO;
            end
            ST_PAD_ZERO: begin
                if (r_fill == FILL_LEN_AT) begin
                    n_state = ST_PAD_LEN;
                end else if (r_fill == FILL_LAST) begin
                    n_state = ST_ROUND;
                end
            end
            ST_PAD_LEN: begin
                if (r_fill == FILL_LAST) begin
                    n_state = ST_ROUND;
                end
            end
            ST_OUT: begin
                if (w_out_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath control; in idle o_stall is low, so i_valid alone marks a take
    always_comb begin
        w_ctrl  = '0;
        w_byte  = PAD_ZERO_BYTE;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                w_byte  = i_data_byte;
                if (i_valid && i_has_byte) begin
                    w_ctrl.wr_byte   = 1'b1;
                    w_ctrl.load_vars = (r_fill == FILL_LAST);
                end
            end
            ST_ROUND: begin
                w_ctrl.step = 1'b1;
            end
            ST_FOLD: begin
                w_ctrl = '0;
            end
            ST_PAD_MARK: begin
                w_byte           = PAD_MARK_BYTE;
                w_ctrl.wr_byte   = 1'b1;
                w_ctrl.load_vars = (r_fill == FILL_LAST);
            end
            ST_PAD_ZERO: begin
                w_ctrl.wr_byte   = (r_fill != FILL_LEN_AT);
                w_ctrl.load_vars = (r_fill == FILL_LAST);
            end
            ST_PAD_LEN: begin
                w_byte           = w_len_byte;
                w_ctrl.wr_byte   = 1'b1;
                w_ctrl.load_vars = (r_fill == FILL_LAST);
            end
            ST_OUT: begin
                o_valid = 1'b1;
            end
            default: w_ctrl = '0;
        endcase
    end

    // fill count, length and chaining words
    always_comb begin
        n_fill  = r_fill;
        n_total = r_total;
        n_chain = r_chain;
        if (w_ctrl.wr_byte) begin
            n_fill = r_fill + 6'd1;
        end
        if ((r_state == ST_IDLE) && w_in_acc && i_has_byte) begin
            n_total = r_total + 61'd1;
        end
        if (r_state == ST_FOLD) begin
            for (int j = 0; j < 8; j++) begin
                n_chain[j] = r_chain[j] + w_vars[j];
            end
        end else if (w_out_acc) begin
            // shift the digest out, refilling with the initial values
            for (int j = 0; j < 7; j++) begin
                n_chain[j] = r_chain[j + 1];
            end
            n_chain[7] = INIT_H[r_oidx];
        end
        if (w_out_done) begin
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_total     <= '0;
            r_chain     <= INIT_H;
            r_round     <= '0;
            r_oidx      <= '0;
            r_last_pend <= 1'b0;
            r_pad       <= 1'b0;
            r_len_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_chain <= n_chain;
            if (r_state == ST_ROUND) begin
                r_round <= r_round + 6'd1;
            end
            if (w_out_acc) begin
                r_oidx <= r_oidx + 3'd1;
            end
            if ((r_state == ST_IDLE) && w_in_acc) begin
                r_last_pend <= i_last_item;
            end else if (r_state == ST_PAD_MARK) begin
                r_last_pend <= 1'b0;
            end
            if (r_state == ST_PAD_MARK) begin
                r_pad <= 1'b1;
            end else if (w_out_done) begin
                r_pad <= 1'b0;
            end
            if ((r_state == ST_PAD_LEN) && (r_fill == FILL_LAST)) begin
                r_len_done <= 1'b1;
            end else if (w_out_done) begin
                r_len_done <= 1'b0;
            end
        end
    end

    assign o_digest_word = r_chain[0];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == LAST_INDEX);

endmodule

// ----- hdl/sha256_checker.sv -----
`include "sha256_hash_engine_macros.svh"

// Port-level checks on the digest run.
module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // no new byte is taken while the digest is going out
    `SHA_ASSERT_NOW(a_busy_in_out, o_valid, o_stall, "input open during digest output")

    // words come out in order, with no gaps
    `SHA_ASSERT_NEXT(a_index_step, o_valid && !i_stall && !o_last_word,
        o_valid && (o_word_index == 3'($past(o_word_index) + 3'd1)),
        "digest word index did not advance")

    // the run ends on the eighth word
    `SHA_ASSERT_NEXT(a_run_end, o_valid && !i_stall && o_last_word, !o_valid,
        "digest output ran past the eighth word")

    // a stalled digest word holds
    `SHA_ASSERT_NEXT(a_hold, o_valid && i_stall,
        o_valid && $stable(o_digest_word) && $stable(o_word_index),
        "stalled digest word changed")

endmodule

bind sha256_hash_engine sha256_checker u_checker (.*);
